### rtl/trde_pkg.sv
`default_nettype none
package trde_pkg;

  localparam int RecBytes = 18;
  localparam int CntW     = 5;
  localparam int FillW    = 21;
  localparam int LenW     = 13;

  typedef enum logic [1:0] {
    OP_RECORD     = 2'd0,
    OP_EXT_HEADER = 2'd1,
    OP_PAYLOAD    = 2'd2,
    OP_RESERVED   = 2'd3
  } opcode_t;

  localparam logic [7:0]       MARKER_BYTE     = 8'h7F;
  localparam logic [7:0]       PACKED_FLAG     = 8'h80;
  localparam logic [6:0]       CTRL_RESERVED   = 7'h7F;
  localparam logic [FillW-1:0] FILL_MAX        = 21'h1FFFFF;
  localparam logic [FillW-1:0] THRESHOLD_RESET = 21'd65536;

  localparam logic [4:0] AC_PLAIN      = 5'h00;
  localparam logic [4:0] AC_EQUAL      = 5'h01;
  localparam logic [4:0] AC_UP_SMALL   = 5'h01;
  localparam logic [4:0] AC_DOWN_SMALL = 5'h09;
  localparam logic [4:0] AC_UP_BASE    = 5'h12;
  localparam logic [4:0] AC_DOWN_BASE  = 5'h15;

  localparam logic [2:0] CC_PLAIN = 3'd0;
  localparam logic [2:0] CC_BYTE  = 3'd6;
  localparam logic [2:0] CC_WORD  = 3'd7;

  typedef struct packed {
    logic [0:RecBytes-1][7:0] bytes;
    logic [CntW-1:0]          count;
    logic                     boundary;
  } rec_t;

endpackage
`default_nettype wire

### rtl/trace_record_delta_encoder.sv
// Channel   Transaction at clk edge   Carries
// input     push && !full             opcode, record fields, payload_byte
// result    pop && !empty             out_byte, last_of_item, packet_boundary
// config    cfg_wen                   packet_threshold (cfg_wdata)
//
// An item is classified and coded combinationally and lands in a two-entry
// record queue; input stalls only while that queue is full.
// Bytes leave the output register at one per cycle while pop is held and bytes
// are queued; a record or extended header is 2 to 18 bytes, a payload item 1.
// The first byte is written to the record queue and then to the output register.
// rst is synchronous; threshold returns to 65536, all history to zero.
`default_nettype none
module trace_record_delta_encoder #(
  parameter int unsigned MAX_PAYLOAD_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [20:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [6:0]  control_code,
  input  logic [7:0]  component,
  input  logic [31:0] address,
  input  logic [63:0] cycle_number,
  input  logic [31:0] record_tag,
  input  logic [12:0] payload_length,
  input  logic [7:0]  payload_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_of_item,
  output logic        packet_boundary
);
  import trde_pkg::*;

  rec_t front_rec, q_rec;
  logic front_push, q_full, q_valid, q_pop;

  assign full = q_full;

  trde_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .accept        (push && !q_full),
    .opcode        (opcode),
    .control_code  (control_code),
    .component     (component),
    .address       (address),
    .cycle_number  (cycle_number),
    .record_tag    (record_tag),
    .payload_length(payload_length),
    .payload_byte  (payload_byte),
    .push          (front_push),
    .rec           (front_rec)
  );

  trde_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (front_push),
    .wdata   (front_rec),
    .pop     (q_pop),
    .rdata   (q_rec),
    .full    (q_full),
    .nonempty(q_valid)
  );

  trde_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_rec          (q_rec),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .last_of_item   (last_of_item),
    .packet_boundary(packet_boundary)
  );

endmodule
`default_nettype wire

### rtl/trde_front.sv
`default_nettype none
module trde_front #(
  parameter int unsigned MAX_PAYLOAD_BYTES = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [20:0]               cfg_wdata,
  input  logic                      accept,
  input  logic [1:0]                opcode,
  input  logic [6:0]                control_code,
  input  logic [7:0]                component,
  input  logic [31:0]               address,
  input  logic [63:0]               cycle_number,
  input  logic [31:0]               record_tag,
  input  logic [12:0]               payload_length,
  input  logic [7:0]                payload_byte,
  output logic                      push,
  output trde_pkg::rec_t            rec
);
  import trde_pkg::*;

  logic [FillW-1:0] threshold;
  logic [31:0]      prev_addr;
  logic [63:0]      prev_cyc;
  logic [FillW-1:0] fill;
  logic [LenW-1:0]  remaining;

  opcode_t          op;
  logic             a_up;
  logic [31:0]      a_d;
  logic [4:0]       ae;
  logic [2:0]       na;
  logic [0:3][7:0]  addr_b;
  logic [63:0]      c_d;
  logic [2:0]       ce;
  logic [3:0]       nc;
  logic [0:7][7:0]  cyc_b;
  logic [0:7][7:0]  tail_b;
  logic             packed_hdr;
  logic [7:0]       hdr0;
  logic [1:0]       h;
  logic [CntW-1:0]  oa, oc, ot;
  logic [CntW-1:0]  n_norm, n_ext, n_sel;
  logic [LenW-1:0]  len_c;
  logic             produce, record_end, boundary;
  logic [FillW:0]   fill_sum;
  logic [FillW-1:0] fill_sat;
  logic [CntW-1:0]  kk;

  assign op = opcode_t'(opcode);

  always_comb begin
    a_up = address > prev_addr;
    a_d  = a_up ? address - prev_addr : prev_addr - address;
    if (address == prev_addr) begin
      ae = AC_EQUAL;
      na = 3'd0;
    end else if (a_d <= 32'd8) begin
      ae = (a_up ? AC_UP_SMALL : AC_DOWN_SMALL) + a_d[4:0];
      na = 3'd0;
    end else if (a_d[31:8] == 24'd0) begin
      ae = a_up ? AC_UP_BASE : AC_DOWN_BASE;
      na = 3'd1;
    end else if (a_d[31:16] == 16'd0) begin
      ae = (a_up ? AC_UP_BASE : AC_DOWN_BASE) + 5'd1;
      na = 3'd2;
    end else if (a_d[31:24] == 8'd0) begin
      ae = (a_up ? AC_UP_BASE : AC_DOWN_BASE) + 5'd2;
      na = 3'd3;
    end else begin
      ae = AC_PLAIN;
      na = 3'd4;
    end
    case (na)
      3'd1:    addr_b = {a_d[7:0], 24'd0};
      3'd2:    addr_b = {a_d[15:0], 16'd0};
      3'd3:    addr_b = {a_d[23:0], 8'd0};
      default: addr_b = address;
    endcase

    c_d = cycle_number - prev_cyc;
    if (c_d <= 64'd4) begin
      ce    = c_d[2:0] + 3'd1;
      nc    = 4'd0;
      cyc_b = cycle_number;
    end else if (c_d[63:8] == 56'd0) begin
      ce    = CC_BYTE;
      nc    = 4'd1;
      cyc_b = {c_d[7:0], 56'd0};
    end else if (c_d[63:16] == 48'd0) begin
      ce    = CC_WORD;
      nc    = 4'd2;
      cyc_b = {c_d[15:0], 48'd0};
    end else begin
      ce    = CC_PLAIN;
      nc    = 4'd8;
      cyc_b = cycle_number;
    end

    packed_hdr = (control_code <= 7'd15) && (component <= 8'd7);
    hdr0 = packed_hdr ? (PACKED_FLAG | {1'b0, component[2:0], control_code[3:0]})
                      : {1'b0, control_code};
    h    = packed_hdr ? 2'd1 : 2'd2;

    if ({19'd0, payload_length} > 32'(MAX_PAYLOAD_BYTES)) begin
      len_c = LenW'(MAX_PAYLOAD_BYTES);
    end else begin
      len_c = payload_length;
    end
    tail_b = {record_tag, {(32 - LenW){1'b0}}, len_c};

    oa     = CntW'(h) + 5'd1;
    oc     = oa + CntW'(na);
    n_norm = oc + CntW'(nc);
    ot     = 5'd2 + CntW'(nc);
    n_ext  = ot + 5'd8;

    case (op)
      OP_RECORD: begin
        produce    = control_code != CTRL_RESERVED;
        record_end = 1'b1;
        n_sel      = n_norm;
      end
      OP_EXT_HEADER: begin
        produce    = 1'b1;
        record_end = len_c == '0;
        n_sel      = n_ext;
      end
      OP_PAYLOAD: begin
        produce    = remaining != '0;
        record_end = remaining == LenW'(1);
        n_sel      = 5'd1;
      end
      default: begin
        produce    = 1'b0;
        record_end = 1'b0;
        n_sel      = 5'd1;
      end
    endcase

    fill_sum = {1'b0, fill} + (FillW + 1)'(n_sel);
    fill_sat = fill_sum[FillW] ? FILL_MAX : fill_sum[FillW-1:0];
    boundary = record_end && (fill_sat >= threshold);

    kk = '0;
    for (int k = 0; k < RecBytes; k++) begin
      kk = CntW'(k);
      case (op)
        OP_RECORD: begin
          if (kk == 5'd0) begin
            rec.bytes[k] = hdr0;
          end else if (kk < CntW'(h)) begin
            rec.bytes[k] = component;
          end else if (kk == CntW'(h)) begin
            rec.bytes[k] = {ae, ce};
          end else if (kk < oc) begin
            rec.bytes[k] = addr_b[2'(kk - oa)];
          end else begin
            rec.bytes[k] = cyc_b[3'(kk - oc)];
          end
        end
        OP_EXT_HEADER: begin
          if (kk == 5'd0) begin
            rec.bytes[k] = MARKER_BYTE;
          end else if (kk == 5'd1) begin
            rec.bytes[k] = {5'd0, ce};
          end else if (kk < ot) begin
            rec.bytes[k] = cyc_b[3'(kk - 5'd2)];
          end else begin
            rec.bytes[k] = tail_b[3'(kk - ot)];
          end
        end
        default: rec.bytes[k] = payload_byte;
      endcase
    end
    rec.count    = n_sel;
    rec.boundary = boundary;
  end

  assign push = accept && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      prev_addr <= '0;
      prev_cyc  <= '0;
      fill      <= '0;
      remaining <= '0;
    end else begin
      if (cfg_wen) begin
        threshold <= cfg_wdata;
      end
      if (push) begin
        fill <= boundary ? '0 : fill_sat;
        if (boundary) begin
          prev_addr <= '0;
          prev_cyc  <= '0;
        end else begin
          if (op == OP_RECORD) begin
            prev_addr <= address;
          end
          if (op == OP_RECORD || op == OP_EXT_HEADER) begin
            prev_cyc <= cycle_number;
          end
        end
        case (op)
          OP_RECORD:     remaining <= '0;
          OP_EXT_HEADER: remaining <= len_c;
          default:       remaining <= remaining - LenW'(1);
        endcase
      end
    end
  end

endmodule
`default_nettype wire

### rtl/trde_queue.sv
`default_nettype none
module trde_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  trde_pkg::rec_t wdata,
  input  logic           pop,
  output trde_pkg::rec_t rdata,
  output logic           full,
  output logic           nonempty
);
  import trde_pkg::*;

  rec_t       store [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] level;

  assign full     = level == 2'd2;
  assign nonempty = level != 2'd0;
  assign rdata    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/trde_back.sv
`default_nettype none
module trde_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  trde_pkg::rec_t q_rec,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic           last_of_item,
  output logic           packet_boundary
);
  import trde_pkg::*;

  logic            out_valid;
  logic [CntW-1:0] idx;
  logic            load, take, is_last;

  assign load    = !out_valid || pop;
  assign take    = load && q_valid;
  assign is_last = idx == (q_rec.count - CntW'(1));
  assign q_pop   = take && is_last;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= q_valid;
      end
      if (take) begin
        idx <= is_last ? '0 : idx + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte        <= q_rec.bytes[idx];
      last_of_item    <= is_last;
      packet_boundary <= is_last && q_rec.boundary;
    end
  end

endmodule
`default_nettype wire

### rtl/trde_checker.sv
`default_nettype none
module trde_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       pop,
  input logic       empty,
  input logic [7:0] out_byte,
  input logic       last_of_item,
  input logic       packet_boundary
);

  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("not idle after reset");

  a_boundary_last: assert property (@(posedge clk) disable iff (rst)
    !empty && packet_boundary |-> last_of_item)
    else $error("packet boundary on a byte that does not end its transaction");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(last_of_item))
    else $error("result changed while stalled");

  a_record_continues: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && !last_of_item |=> !empty)
    else $error("gap inside a record");

endmodule

bind trace_record_delta_encoder trde_checker u_trde_checker (
  .clk            (clk),
  .rst            (rst),
  .full           (full),
  .pop            (pop),
  .empty          (empty),
  .out_byte       (out_byte),
  .last_of_item   (last_of_item),
  .packet_boundary(packet_boundary)
);
`default_nettype wire

### tb/trace_record_delta_encoder_tb.sv
`timescale 1ns / 100ps
module trace_record_delta_encoder_tb;
  import trde_pkg::*;

  localparam int MAX_PAYLOAD    = 4096;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    opcode_t          op;
    logic [6:0]       ctrl;
    logic [7:0]       comp;
    logic [31:0]      addr;
    logic [63:0]      cyc;
    logic [31:0]      tag;
    logic [LenW-1:0]  len;
    logic [7:0]       pb;
  } trace_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       boundary;
  } stream_byte_t;

  class trace_byte_scoreboard;
    logic [FillW-1:0] threshold;
    logic [31:0]      last_addr;
    logic [63:0]      last_cycle;
    logic [FillW-1:0] fill_count;
    logic [LenW-1:0]  payload_left;
    logic [7:0]       record_bytes[$];
    stream_byte_t     expected_bytes[$];
    int               errors;

    function new();
      threshold    = THRESHOLD_RESET;
      last_addr    = '0;
      last_cycle   = '0;
      fill_count   = '0;
      payload_left = '0;
      errors       = 0;
    endfunction

    function logic [2:0] cycle_code(logic [63:0] cur);
      logic [63:0] d;
      logic [2:0]  c;
      d = cur - last_cycle;
      if (d <= 64'd4) begin
        c = d[2:0] + 3'd1;
      end else if (d <= 64'hFF) begin
        c = CC_BYTE;
        record_bytes.push_back(d[7:0]);
      end else if (d <= 64'hFFFF) begin
        c = CC_WORD;
        record_bytes.push_back(d[15:8]);
        record_bytes.push_back(d[7:0]);
      end else begin
        c = CC_PLAIN;
        for (int i = 7; i >= 0; i--) record_bytes.push_back(cur[8*i +: 8]);
      end
      last_cycle = cur;
      return c;
    endfunction

    function logic [4:0] address_code(logic [31:0] a);
      logic [31:0] d;
      logic [4:0]  c;
      logic [4:0]  near;
      logic [4:0]  base;
      if (a == last_addr) begin
        c = AC_EQUAL;
      end else begin
        if (a > last_addr) begin
          d    = a - last_addr;
          near = AC_UP_SMALL;
          base = AC_UP_BASE;
        end else begin
          d    = last_addr - a;
          near = AC_DOWN_SMALL;
          base = AC_DOWN_BASE;
        end
        if (d <= 32'd8) begin
          c = d[4:0] + near;
        end else if (d <= 32'hFF) begin
          c = base;
          record_bytes.push_back(d[7:0]);
        end else if (d <= 32'hFFFF) begin
          c = base + 5'd1;
          record_bytes.push_back(d[15:8]);
          record_bytes.push_back(d[7:0]);
        end else if (d <= 32'hFFFFFF) begin
          c = base + 5'd2;
          record_bytes.push_back(d[23:16]);
          record_bytes.push_back(d[15:8]);
          record_bytes.push_back(d[7:0]);
        end else begin
          c = AC_PLAIN;
        end
      end
      if (c == AC_PLAIN) begin
        for (int i = 3; i >= 0; i--) record_bytes.push_back(a[8*i +: 8]);
      end
      last_addr = a;
      return c;
    endfunction

    // packet closes only at a record end
    function void close_item(logic record_end);
      logic [21:0]  sum;
      logic         closed;
      stream_byte_t e;
      int           n;
      n   = record_bytes.size();
      sum = {1'b0, fill_count} + 22'(n);
      fill_count = (sum > {1'b0, FILL_MAX}) ? FILL_MAX : sum[FillW-1:0];
      closed = record_end && (fill_count >= threshold);
      if (closed) begin
        last_addr  = '0;
        last_cycle = '0;
        fill_count = '0;
      end
      for (int k = 0; k < n; k++) begin
        e.value    = record_bytes[k];
        e.last     = (k == n - 1);
        e.boundary = (k == n - 1) && closed;
        expected_bytes.push_back(e);
      end
      record_bytes.delete();
    endfunction

    function void note_item(trace_item_t it);
      logic [LenW-1:0] len;
      int              enc_at;
      logic [4:0]      ac;
      logic [2:0]      cc;
      record_bytes.delete();
      case (it.op)
        OP_RECORD: begin
          if (it.ctrl != CTRL_RESERVED) begin
            payload_left = '0;
            if (it.ctrl <= 7'd15 && it.comp <= 8'd7) begin
              record_bytes.push_back(PACKED_FLAG | {1'b0, it.comp[2:0], it.ctrl[3:0]});
            end else begin
              record_bytes.push_back({1'b0, it.ctrl});
              record_bytes.push_back(it.comp);
            end
            enc_at = record_bytes.size();
            record_bytes.push_back(8'h00);
            ac = address_code(it.addr);
            cc = cycle_code(it.cyc);
            record_bytes[enc_at] = {ac, cc};
            close_item(1'b1);
          end
        end
        OP_EXT_HEADER: begin
          len = (it.len > LenW'(MAX_PAYLOAD)) ? LenW'(MAX_PAYLOAD) : it.len;
          record_bytes.push_back(MARKER_BYTE);
          enc_at = record_bytes.size();
          record_bytes.push_back(8'h00);
          cc = cycle_code(it.cyc);
          record_bytes[enc_at] = {5'd0, cc};
          for (int i = 3; i >= 0; i--) record_bytes.push_back(it.tag[8*i +: 8]);
          record_bytes.push_back(8'h00);
          record_bytes.push_back(8'h00);
          record_bytes.push_back({3'b000, len[12:8]});
          record_bytes.push_back(len[7:0]);
          payload_left = len;
          close_item(len == '0);
        end
        OP_PAYLOAD: begin
          if (payload_left != '0) begin
            payload_left = payload_left - LenW'(1);
            record_bytes.push_back(it.pb);
            close_item(payload_left == '0);
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 60) $display("%0t mismatch: %s", $time, what);
    endtask

    task check_byte(logic [7:0] value, logic last, logic boundary);
      stream_byte_t e;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h arrived with nothing expected", value));
        return;
      end
      e = expected_bytes.pop_front();
      if (value !== e.value)
        report_mismatch($sformatf("out_byte %02h, expected %02h", value, e.value));
      if (last !== e.last)
        report_mismatch($sformatf("last_of_item %b, expected %b (byte %02h)",
                                  last, e.last, e.value));
      if (boundary !== e.boundary)
        report_mismatch($sformatf("packet_boundary %b, expected %b (byte %02h)",
                                  boundary, e.boundary, e.value));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [20:0] cfg_wdata = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  opcode = '0;
  logic [6:0]  control_code = '0;
  logic [7:0]  component = '0;
  logic [31:0] address = '0;
  logic [63:0] cycle_number = '0;
  logic [31:0] record_tag = '0;
  logic [12:0] payload_length = '0;
  logic [7:0]  payload_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_item;
  logic        packet_boundary;

  trace_byte_scoreboard sb;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_requests = 0;
  int holds_taken = 0;
  int rx_wait = 0;
  int quiet_cycles = 0;

  trace_record_delta_encoder #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .push           (push),
    .full           (full),
    .opcode         (opcode),
    .control_code   (control_code),
    .component      (component),
    .address        (address),
    .cycle_number   (cycle_number),
    .record_tag     (record_tag),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .last_of_item   (last_of_item),
    .packet_boundary(packet_boundary)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: check, then pick next pop
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_byte(out_byte, last_of_item, packet_boundary);
      if (hold_requests != holds_taken) begin
        holds_taken = hold_requests;
        rx_wait     = RX_HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        pop <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        rx_wait = $urandom_range(0, 17);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic trace_item_t noise_fields();
    trace_item_t it;
    it.op   = OP_RESERVED;
    it.ctrl = 7'($urandom);
    it.comp = 8'($urandom);
    it.addr = $urandom;
    it.cyc  = {32'($urandom), 32'($urandom)};
    it.tag  = $urandom;
    it.len  = LenW'($urandom);
    it.pb   = 8'($urandom);
    return it;
  endfunction

  function automatic trace_item_t make_record(logic [6:0] ctrl, logic [7:0] comp,
                                              logic [31:0] addr, logic [63:0] cyc);
    trace_item_t it;
    it      = noise_fields();
    it.op   = OP_RECORD;
    it.ctrl = ctrl;
    it.comp = comp;
    it.addr = addr;
    it.cyc  = cyc;
    return it;
  endfunction

  function automatic trace_item_t make_header(logic [63:0] cyc, logic [31:0] tag,
                                              logic [LenW-1:0] len);
    trace_item_t it;
    it     = noise_fields();
    it.op  = OP_EXT_HEADER;
    it.cyc = cyc;
    it.tag = tag;
    it.len = len;
    return it;
  endfunction

  function automatic trace_item_t make_payload(logic [7:0] pb);
    trace_item_t it;
    it    = noise_fields();
    it.op = OP_PAYLOAD;
    it.pb = pb;
    return it;
  endfunction

  function automatic logic [31:0] next_address();
    logic [31:0] d;
    case ($urandom_range(0, 6))
      0: d = 32'd0;
      1: d = $urandom_range(1, 8);
      2: d = $urandom_range(9, 255);
      3: d = $urandom_range(256, 65535);
      4: d = $urandom_range(65536, 32'hFFFFFF);
      5: d = $urandom_range(32'h1000000, 32'hFFFFFFFF);
      default: return $urandom;
    endcase
    return $urandom_range(0, 1) ? sb.last_addr + d : sb.last_addr - d;
  endfunction

  function automatic logic [63:0] next_cycle();
    logic [63:0] d;
    case ($urandom_range(0, 5))
      0: d = 64'($urandom_range(0, 4));
      1: d = 64'($urandom_range(5, 255));
      2: d = 64'($urandom_range(256, 65535));
      3: d = {32'($urandom_range(0, 3)), 32'($urandom)};
      4: d = -64'($urandom_range(1, 300));
      default: return {32'($urandom), 32'($urandom)};
    endcase
    return sb.last_cycle + d;
  endfunction

  function automatic trace_item_t random_record();
    logic [6:0] ctrl;
    logic [7:0] comp;
    if ($urandom_range(0, 1)) begin
      ctrl = 7'($urandom_range(0, 15));
      comp = 8'($urandom_range(0, 7));
    end else begin
      ctrl = 7'($urandom_range(0, 126));
      comp = 8'($urandom);
    end
    return make_record(ctrl, comp, next_address(), next_cycle());
  endfunction

  task automatic pause_input(int cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_item(trace_item_t it);
    push           <= 1'b1;
    opcode         <= it.op;
    control_code   <= it.ctrl;
    component      <= it.comp;
    address        <= it.addr;
    cycle_number   <= it.cyc;
    record_tag     <= it.tag;
    payload_length <= it.len;
    payload_byte   <= it.pb;
    do @(posedge clk); while (full);
    sb.note_item(it);
    if (tx_idle && $urandom_range(0, 5) == 0) pause_input($urandom_range(1, 18));
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(logic [20:0] value);
    drain_results();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen      <= 1'b0;
    sb.threshold = value;
  endtask

  // mostly well-formed records and extended transactions, some noise
  task automatic run_phase(int count);
    int              done;
    int              sent;
    logic [LenW-1:0] len;
    done = 0;
    while (done < count) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
          send_item(random_record());
          done++;
        end
        13, 14, 15, 16: begin
          if ($urandom_range(0, 7) == 0) len = LenW'($urandom_range(4096, 8191));
          else len = LenW'($urandom_range(0, 6));
          send_item(make_header(next_cycle(), $urandom, len));
          if (len > 13'd6) sent = $urandom_range(0, 3);
          else if ($urandom_range(0, 5) == 0) sent = $urandom_range(0, len);
          else sent = len;
          repeat (sent) send_item(make_payload(8'($urandom)));
          done += 1 + sent;
        end
        17: send_item(make_payload(8'($urandom)));
        18: send_item(noise_fields());
        default: send_item(make_record(CTRL_RESERVED, 8'($urandom), next_address(),
                                       next_cycle()));
      endcase
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_item(make_record(7'd0, 8'd0, 32'd0, 64'd0));
    send_item(make_record(7'd15, 8'd7, sb.last_addr + 32'd8, sb.last_cycle + 64'd4));
    send_item(make_record(7'd16, 8'd7, sb.last_addr - 32'd8, sb.last_cycle + 64'd5));
    send_item(make_record(7'd0, 8'd8, sb.last_addr + 32'd255, sb.last_cycle + 64'd255));
    send_item(make_record(7'd126, 8'd255, sb.last_addr + 32'd256, sb.last_cycle + 64'd256));
    send_item(make_record(7'd64, 8'd128, sb.last_addr + 32'hFFFF, sb.last_cycle + 64'hFFFF));
    send_item(make_record(7'd1, 8'd1, sb.last_addr + 32'h10000, sb.last_cycle + 64'h10000));
    send_item(make_record(7'd2, 8'd3, sb.last_addr + 32'hFFFFFF, '1));
    // cycle wraps through zero
    send_item(make_record(7'd3, 8'd4, sb.last_addr + 32'h1000000, 64'd0));
    send_item(make_record(7'd9, 8'd5, sb.last_addr - 32'd1, sb.last_cycle));
    send_item(make_record(7'd10, 8'd6, sb.last_addr - 32'd9, sb.last_cycle + 64'd3));
    send_item(make_record(7'd11, 8'd2, sb.last_addr - 32'h100, sb.last_cycle + 64'd1));
    send_item(make_record(7'd12, 8'd3, sb.last_addr - 32'h10000, sb.last_cycle + 64'd2));
    send_item(make_record(7'd13, 8'd0, sb.last_addr - 32'h1000000, sb.last_cycle + 64'd200));
    send_item(make_record(7'd14, 8'd1, 32'hFFFFFFFF, sb.last_cycle - 64'd1));
    send_item(make_record(CTRL_RESERVED, 8'd0, 32'd5, 64'd5));
    send_item(noise_fields());
    send_item(make_payload(8'h33));
    send_item(make_header(sb.last_cycle, 32'hFFFFFFFF, 13'd0));
    send_item(make_header(sb.last_cycle + 64'd7, 32'h0, 13'd3));
    send_item(make_payload(8'h00));
    send_item(make_payload(8'hFF));
    send_item(make_payload(8'hA5));
    // over-long length is clamped, then a new record cuts the payload short
    send_item(make_header(sb.last_cycle + 64'd1, 32'h12345678, 13'h1FFF));
    send_item(make_payload(8'h5A));
    send_item(make_record(7'd5, 8'd2, sb.last_addr, sb.last_cycle + 64'd2));

    set_threshold(21'd0);
    run_phase(24);

    set_threshold(21'd1);
    tx_idle = 1'b0;
    hold_requests++;
    run_phase(24);

    set_threshold(21'd37);
    tx_idle = 1'b1;
    run_phase(24);

    set_threshold(21'h1FFFFF);
    run_phase(24);

    set_threshold(21'h100000);
    run_phase(16);

    set_threshold(21'd150);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_phase(28);

    drain_results();
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
